/* hdl/ctft_pkg.sv */
// Shared types for the CAN transfer frame tracker: input and result words,
// status and kind codes, decoded-identifier and table-result structs.
// No dependencies.
`default_nettype none

package ctft_pkg;

    localparam int KEY_W = 30;

    typedef enum logic [2:0] {
        ST_NOT_OURS = 3'd0,
        ST_V0       = 3'd1,
        ST_ORPHAN   = 3'd2,
        ST_SINGLE   = 3'd3,
        ST_MULTI    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_MESSAGE  = 2'd0,
        KIND_REQUEST  = 2'd1,
        KIND_RESPONSE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [28:0] can_id;
        logic        extended_frame;
        logic        error_frame;
        logic [7:0]  tail_info;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        t_kind       frame_kind;
        logic [2:0]  priority_res;
        logic [12:0] port_id;
        logic [6:0]  source_node;
        logic [6:0]  dest_node;
        logic        anonymous;
        logic [31:0] transfer_seq;
        logic [15:0] fragment_index;
        logic        more_fragments;
        logic        toggle_repeat;
    } t_out_word;

    // Fields taken apart from the identifier and the tail byte.
    typedef struct packed {
        logic        start;
        logic        eot;
        logic        toggle;
        t_kind       kind;
        logic [2:0]  prio;
        logic [12:0] port;
        logic [6:0]  src;
        logic [6:0]  dst;
        logic        anon;
    } t_dec;

    // Answer of the transfer table for the word under decode.
    typedef struct packed {
        logic        hit;
        logic        full;
        logic [31:0] seq;
        logic [15:0] frag;
        logic        toggle_err;
    } t_tbl_res;

endpackage

`default_nettype wire

/* hdl/ctft_decode.sv */
// Identifier and tail-byte decoder: builds the transfer key and the
// decoded header fields. Depends on ctft_pkg.
`default_nettype none

module ctft_decode
    import ctft_pkg::*;
(
    input  var t_in_word         i_word,
    output logic [KEY_W-1:0]     o_key,
    output t_dec                 o_dec
);

    localparam int TB_START_BIT  = 7;
    localparam int TB_END_BIT    = 6;
    localparam int TB_TOGGLE_BIT = 5;
    localparam int ID_SERVICE    = 25;
    localparam int ID_BIT24      = 24;

    logic        w_service;
    logic        w_bit24;
    logic [4:0]  w_tid;
    logic [6:0]  w_src;
    logic [6:0]  w_dst;
    logic [12:0] w_subject;
    logic [8:0]  w_svc_id;

    assign w_service = i_word.can_id[ID_SERVICE];
    assign w_bit24   = i_word.can_id[ID_BIT24];
    assign w_tid     = i_word.tail_info[4:0];
    assign w_src     = i_word.can_id[6:0];
    assign w_dst     = i_word.can_id[13:7];
    assign w_subject = i_word.can_id[20:8];
    assign w_svc_id  = i_word.can_id[22:14];

    always_comb begin
        if (w_service) begin
            o_key = {w_tid, w_src, w_dst, w_svc_id, w_bit24, 1'b1};
        end else begin
            // Subject and source overlap in the message key and merge by OR.
            o_key = {16'd0, w_subject, 1'b0}
                  | {12'd0, w_src, 11'd0}
                  | {7'd0, w_tid, 18'd0};
        end
    end

    always_comb begin
        o_dec.start  = i_word.tail_info[TB_START_BIT];
        o_dec.eot    = i_word.tail_info[TB_END_BIT];
        o_dec.toggle = i_word.tail_info[TB_TOGGLE_BIT];
        o_dec.prio   = i_word.can_id[28:26];
        o_dec.src    = w_src;
        if (w_service) begin
            o_dec.kind = w_bit24 ? KIND_REQUEST : KIND_RESPONSE;
            o_dec.port = {4'd0, w_svc_id};
            o_dec.dst  = w_dst;
            o_dec.anon = 1'b0;
        end else begin
            o_dec.kind = KIND_MESSAGE;
            o_dec.port = w_subject;
            o_dec.dst  = 7'd0;
            o_dec.anon = w_bit24;
        end
    end

endmodule

`default_nettype wire

/* hdl/ctft_table.sv */
// Associative transfer table: key compare across all entries, fill count,
// per-entry toggle, fragment and sequence, and the transfer counter.
// Depends on ctft_pkg.
`default_nettype none

module ctft_table
    import ctft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var logic [KEY_W-1:0] i_key,
    input  var logic             i_start,
    input  var logic             i_toggle,
    input  var logic             i_update,
    output t_tbl_res             o_res
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    // Entries are taken lowest first and never released, so the valid
    // entries are exactly those below the fill count.
    logic [FILL_W-1:0] r_fill;
    logic [31:0]       r_counter;
    logic [KEY_W-1:0]  r_key  [TABLE_ENTRIES];
    logic              r_tog  [TABLE_ENTRIES];
    logic [15:0]       r_frag [TABLE_ENTRIES];
    logic [31:0]       r_seq  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [IDX_W-1:0]         w_hit_idx;
    logic [IDX_W-1:0]         w_wr_idx;

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit[i] = (FILL_W'(i) < r_fill) && (r_key[i] == i_key);
            if (w_hit[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
    end

    assign w_wr_idx = o_res.hit ? w_hit_idx : r_fill[IDX_W-1:0];

    always_comb begin
        o_res.hit  = |w_hit;
        o_res.full = (r_fill == FILL_W'(TABLE_ENTRIES));
        if (o_res.hit && !i_start) begin
            o_res.seq        = r_seq[w_hit_idx];
            o_res.frag       = r_frag[w_hit_idx] + 16'd1;
            o_res.toggle_err = (i_toggle == r_tog[w_hit_idx]);
        end else begin
            o_res.seq        = r_counter;
            o_res.frag       = 16'd0;
            o_res.toggle_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_counter <= 32'd0;
        end else if (i_update) begin
            if (!o_res.hit) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_start) begin
                r_counter <= r_counter + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_key[w_wr_idx]  <= i_key;
            r_tog[w_wr_idx]  <= i_toggle;
            r_frag[w_wr_idx] <= o_res.frag;
            r_seq[w_wr_idx]  <= o_res.seq;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("key matches more than one entry");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fill != $past(r_fill)) |->
            (r_fill == $past(r_fill) + FILL_W'(1)) && $past(i_update && !o_res.hit))
        else $error("fill count changed without an allocation");

    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_counter != $past(r_counter)) |->
            $past(i_update && i_start))
        else $error("transfer counter moved without a start frame");
`endif

endmodule

`default_nettype wire

/* hdl/can_transfer_frame_tracker.sv */
// Top level of the CAN transfer frame tracker: input register, frame
// classification and result register. Depends on ctft_pkg, ctft_decode
// and ctft_table.
//
//   Channel   Direction  Handshake                  Word
//   input     in         i_in_valid / o_in_ready    t_in_word  (one CAN frame)
//   result    out        o_out_valid / i_out_ready  t_out_word (one classification)
//
// Each accepted word yields exactly one result word: it is held in the input
// register and loaded into the result register when the stage advances. A new
// word can be accepted in every cycle while the consumer takes results; the
// clock period is set by the key compare across all table entries followed
// by the fragment increment. Synchronous active-low reset empties the table
// (fill count to zero) and clears the transfer counter and both valid flags.
// When the result register is held by the consumer, the input register
// holds too and o_in_ready drops once both are full.
`default_nettype none

module can_transfer_frame_tracker
    import ctft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_in_valid,
    output logic          o_in_ready,
    input  var t_in_word  i_in_word,
    output logic          o_out_valid,
    input  var logic      i_out_ready,
    output t_out_word     o_out_word
);

    logic             r_in_valid;
    t_in_word         r_in;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    logic             w_advance;
    logic [KEY_W-1:0] w_key;
    t_dec             w_dec;
    t_tbl_res         w_tbl;
    logic             w_multi;
    logic             w_update;

    // The stage moves forward when it holds a word and the result register
    // is free or being emptied in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    ctft_decode u_decode (
        .i_word (r_in),
        .o_key  (w_key),
        .o_dec  (w_dec)
    );

    ctft_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (w_key),
        .i_start  (w_dec.start),
        .i_toggle (w_dec.toggle),
        .i_update (w_update),
        .o_res    (w_tbl)
    );

    // A frame is part of a multi-frame transfer unless it both starts and
    // ends one.
    assign w_multi = !(w_dec.start && w_dec.eot);

    always_comb begin
        n_out = '0;
        if (r_in.error_frame || !r_in.extended_frame) begin
            n_out.status = ST_NOT_OURS;
        end else if (w_dec.start && !w_dec.toggle) begin
            // A start frame with a clear toggle follows the older protocol.
            n_out.status = ST_V0;
        end else if (w_multi && !w_dec.start && !w_tbl.hit) begin
            n_out.status = ST_ORPHAN;
        end else begin
            n_out.frame_kind   = w_dec.kind;
            n_out.priority_res = w_dec.prio;
            n_out.port_id      = w_dec.port;
            n_out.source_node  = w_dec.src;
            n_out.dest_node    = w_dec.dst;
            n_out.anonymous    = w_dec.anon;
            if (!w_multi) begin
                n_out.status = ST_SINGLE;
            end else if (!w_tbl.hit && w_tbl.full) begin
                n_out.status         = ST_FULL;
                n_out.more_fragments = !w_dec.eot;
            end else begin
                n_out.status         = ST_MULTI;
                n_out.more_fragments = !w_dec.eot;
                n_out.transfer_seq   = w_tbl.seq;
                n_out.fragment_index = w_tbl.frag;
                n_out.toggle_repeat  = w_tbl.toggle_err;
            end
        end
    end

    // The table changes only for frames that are tracked, and only in the
    // cycle in which their result is registered.
    assign w_update = w_advance && (n_out.status == ST_MULTI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire
